### rtl/core/column_delta_rle_encoder_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the column delta RLE encoder.
// ---------------------------------------------------------------------------
`ifndef COLUMN_DELTA_RLE_ENCODER_ASSERT_SVH
`define COLUMN_DELTA_RLE_ENCODER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define CDR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define CDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/cdre_pkg.sv
// ---------------------------------------------------------------------------
// cdre_pkg
// Constants and codes shared by the column delta RLE encoder.
// ---------------------------------------------------------------------------
package cdre_pkg;

  // Default sizes.
  localparam int unsigned DEF_MAX_HEIGHT   = 128;
  localparam int unsigned DEF_RECORD_DEPTH = 384;

  // Longest repeat one packed code can describe.
  localparam logic [5:0] RUN_CAP     = 6'd32;
  // Packed code base; colours above it always get a code word.
  localparam logic [7:0] CODE_BASE   = 8'hdf;
  // Record byte for a column without changed pixels.
  localparam logic [7:0] EMPTY_COL   = 8'hff;
  // First record byte for packed and raw records.
  localparam logic [7:0] PACKED_TAG  = 8'h80;
  localparam logic [7:0] RAW_TAG     = 8'h00;

  // Pending frame-type word.
  typedef enum logic [1:0] {
    FB_NONE  = 2'd0,
    FB_DELTA = 2'd1,
    FB_KEY   = 2'd2
  } frame_pend_t;

endpackage

### rtl/core/cdre_ram.sv
// ---------------------------------------------------------------------------
// cdre_ram
// Generic single write port RAM with one registered read port.
// ---------------------------------------------------------------------------
module cdre_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/column_delta_rle_encoder.sv
// ---------------------------------------------------------------------------
// column_delta_rle_encoder
// Per-column delta run-length encoder for palette animation frames.
// ---------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low. With
// in_action low it pushes one pixel of the column (top to bottom); with
// in_action high it reads the next queued word. Every item gives exactly one
// word on the out_ ports, marked by out_strobe for one cycle; the receiver
// cannot stall, so the word must be taken in that cycle.
// A push that does not end a column answers in the next cycle and the block
// is ready again at once. A read of the frame-type word or an empty read also
// answers next cycle; a record read passes through S_EMIT for the RAM read.
// A push with in_column_end set starts the encoder, which walks the column
// once through the column RAM: S_RD fetches and S_EV handles each pixel,
// S_FL0 and S_FL1 flush each packed group, S_CLOSE, S_HD0 and S_HD1 close
// each run, and S_FIN and S_FIN2 finish, as the column RAM has a single read
// port and the packed record RAM one write port. busy stays high throughout.
// Pushes are refused while a record is pending or while a frame start meets
// a pending frame-type word. Reset clears all pending output and the fill
// count; the RAMs are not cleared and are never read before written.
// ---------------------------------------------------------------------------
module column_delta_rle_encoder
  import cdre_pkg::*;
#(
  parameter int unsigned MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int unsigned RECORD_DEPTH = DEF_RECORD_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_action,
  input  logic [7:0] in_cur_pixel,
  input  logic [7:0] in_prev_pixel,
  input  logic       in_key_frame,
  input  logic       in_frame_start,
  input  logic       in_column_end,
  output logic       out_strobe,
  output logic       out_byte_valid,
  output logic [7:0] out_byte,
  output logic       out_record_last,
  output logic       out_refused
);

  `include "column_delta_rle_encoder_assert.svh"

  localparam int unsigned CAW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RAW_AW = $clog2(RECORD_DEPTH);
  localparam int unsigned PW_A   = $clog2(3 * MAX_HEIGHT + 4);
  localparam int unsigned PW_B   = $clog2(RECORD_DEPTH + 1);
  localparam int unsigned PW     = (PW_A > PW_B) ? PW_A : PW_B;

  typedef enum logic [3:0] {
    S_IDLE, S_EMIT, S_RD, S_EV, S_CLOSE, S_HD0, S_HD1,
    S_FL0, S_FL1, S_FIN, S_FIN2
  } state_t;

  // Control registers.
  state_t            state_r, state_nxt;
  state_t            fl_ret_r, fl_ret_nxt;
  state_t            cl_ret_r, cl_ret_nxt;
  frame_pend_t       fb_r, fb_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [PW-1:0]     emit_ptr_r, emit_ptr_nxt;
  logic [PW-1:0]     emit_len_r, emit_len_nxt;
  logic              sel_r, sel_nxt;
  logic              strobe_r, strobe_nxt;

  // Encoder datapath registers.
  logic [CNT_W-1:0]  y_r, y_nxt;
  logic [PW-1:0]     pu_r, pu_nxt;
  logic [PW-1:0]     pc_r, pc_nxt;
  logic [PW-1:0]     run_pu_r, run_pu_nxt;
  logic [PW-1:0]     run_pc_r, run_pc_nxt;
  logic              in_run_r, in_run_nxt;
  logic [7:0]        skip_r, skip_nxt;
  logic [5:0]        grp_n_r, grp_n_nxt;
  logic [7:0]        grp_c_r, grp_c_nxt;

  // Output word registers.
  logic              bv_r, bv_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic              ref_r, ref_nxt;

  // RAM controls.
  logic              col_we;
  logic [CAW-1:0]    col_waddr;
  logic [8:0]        col_wdata;
  logic              col_re;
  logic [8:0]        col_rdata;
  logic              raw_we;
  logic [PW-1:0]     raw_waddr;
  logic [7:0]        raw_wdata;
  logic [7:0]        raw_rdata;
  logic              pk_we;
  logic [PW-1:0]     pk_waddr;
  logic [7:0]        pk_wdata;
  logic [7:0]        pk_rdata;
  logic              raw_we_g;
  logic              pk_we_g;

  // Push helpers.
  logic [CNT_W-1:0]  fill_eff;
  logic              fill_room;
  logic              refuse;
  logic              mark_in;
  logic              ev_mark;
  logic [7:0]        ev_pix;
  logic [PW-1:0]     len_full;

  assign fill_eff  = in_frame_start ? '0 : fill_r;
  assign fill_room = fill_eff < CNT_W'(MAX_HEIGHT);
  assign refuse    = (emit_len_r != '0) || (in_frame_start && (fb_r != FB_NONE));
  assign mark_in   = in_key_frame ? (in_cur_pixel != 8'h00)
                                  : (in_cur_pixel != in_prev_pixel);
  assign ev_mark   = col_rdata[8];
  assign ev_pix    = col_rdata[7:0];
  assign len_full  = (pc_r < pu_r) ? pc_r : pu_r;

  assign col_waddr = fill_eff[CAW-1:0];
  assign col_wdata = {mark_in, in_cur_pixel};

  // Sequencer and shared datapath.
  always_comb begin
    state_nxt    = state_r;
    fl_ret_nxt   = fl_ret_r;
    cl_ret_nxt   = cl_ret_r;
    fb_nxt       = fb_r;
    fill_nxt     = fill_r;
    emit_ptr_nxt = emit_ptr_r;
    emit_len_nxt = emit_len_r;
    sel_nxt      = sel_r;
    strobe_nxt   = 1'b0;
    y_nxt        = y_r;
    pu_nxt       = pu_r;
    pc_nxt       = pc_r;
    run_pu_nxt   = run_pu_r;
    run_pc_nxt   = run_pc_r;
    in_run_nxt   = in_run_r;
    skip_nxt     = skip_r;
    grp_n_nxt    = grp_n_r;
    grp_c_nxt    = grp_c_r;
    bv_nxt       = bv_r;
    byte_nxt     = byte_r;
    last_nxt     = last_r;
    ref_nxt      = ref_r;
    col_we       = 1'b0;
    col_re       = 1'b0;
    raw_we       = 1'b0;
    raw_waddr    = pu_r;
    raw_wdata    = ev_pix;
    pk_we        = 1'b0;
    pk_waddr     = pc_r;
    pk_wdata     = grp_c_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          strobe_nxt = 1'b1;
          bv_nxt     = 1'b0;
          byte_nxt   = 8'h00;
          last_nxt   = 1'b0;
          ref_nxt    = 1'b0;
          if (in_action) begin
            if (fb_r != FB_NONE) begin
              bv_nxt   = 1'b1;
              byte_nxt = 8'(fb_r == FB_KEY);
              fb_nxt   = FB_NONE;
            end else if (emit_len_r != '0) begin
              strobe_nxt = 1'b0;
              state_nxt  = S_EMIT;
            end
          end else if (refuse) begin
            ref_nxt = 1'b1;
          end else begin
            if (in_frame_start) begin
              fb_nxt = in_key_frame ? FB_KEY : FB_DELTA;
            end
            col_we   = fill_room;
            fill_nxt = fill_room ? fill_eff + CNT_W'(1) : fill_eff;
            if (in_column_end) begin
              strobe_nxt = 1'b0;
              state_nxt  = S_RD;
              y_nxt      = '0;
              pu_nxt     = PW'(2);
              pc_nxt     = PW'(2);
              in_run_nxt = 1'b0;
              skip_nxt   = 8'h00;
              grp_n_nxt  = 6'd0;
            end
          end
        end
      end

      // Record word is out of the RAM now.
      S_EMIT: begin
        strobe_nxt = 1'b1;
        bv_nxt     = 1'b1;
        byte_nxt   = sel_r ? pk_rdata : raw_rdata;
        last_nxt   = (emit_ptr_r + PW'(1)) == emit_len_r;
        ref_nxt    = 1'b0;
        if ((emit_ptr_r + PW'(1)) >= emit_len_r) begin
          emit_ptr_nxt = '0;
          emit_len_nxt = '0;
        end else begin
          emit_ptr_nxt = emit_ptr_r + PW'(1);
        end
        state_nxt = S_IDLE;
      end

      // Fetch the next pixel, or wrap up the column.
      S_RD: begin
        if (y_r < fill_r) begin
          col_re    = 1'b1;
          state_nxt = S_EV;
        end else if (in_run_r) begin
          cl_ret_nxt = S_FIN;
          state_nxt  = S_CLOSE;
        end else begin
          state_nxt = S_FIN;
        end
      end

      // Handle the fetched pixel.
      S_EV: begin
        if (!ev_mark) begin
          if (in_run_r) begin
            cl_ret_nxt = S_EV;
            state_nxt  = S_CLOSE;
          end else begin
            skip_nxt  = skip_r + 8'd1;
            y_nxt     = y_r + CNT_W'(1);
            state_nxt = S_RD;
          end
        end else if (!in_run_r) begin
          in_run_nxt = 1'b1;
          run_pu_nxt = pu_r;
          run_pc_nxt = pc_r;
          pu_nxt     = pu_r + PW'(2);
          pc_nxt     = pc_r + PW'(2);
          grp_n_nxt  = 6'd0;
        end else if ((grp_n_r != 6'd0) &&
                     ((ev_pix != grp_c_r) || (grp_n_r == RUN_CAP))) begin
          fl_ret_nxt = S_EV;
          state_nxt  = S_FL0;
        end else begin
          raw_we    = 1'b1;
          pu_nxt    = pu_r + PW'(1);
          grp_c_nxt = ev_pix;
          grp_n_nxt = grp_n_r + 6'd1;
          y_nxt     = y_r + CNT_W'(1);
          state_nxt = S_RD;
        end
      end

      // End of a run: flush the open group, then write both headers.
      S_CLOSE: begin
        if (grp_n_r != 6'd0) begin
          fl_ret_nxt = S_CLOSE;
          state_nxt  = S_FL0;
        end else begin
          state_nxt = S_HD0;
        end
      end

      S_HD0: begin
        raw_we    = 1'b1;
        raw_waddr = run_pu_r;
        raw_wdata = 8'(pu_r - run_pu_r - PW'(2));
        pk_we     = 1'b1;
        pk_waddr  = run_pc_r;
        pk_wdata  = 8'(pc_r - run_pc_r - PW'(2));
        state_nxt = S_HD1;
      end

      S_HD1: begin
        raw_we     = 1'b1;
        raw_waddr  = run_pu_r + PW'(1);
        raw_wdata  = skip_r;
        pk_we      = 1'b1;
        pk_waddr   = run_pc_r + PW'(1);
        pk_wdata   = skip_r;
        in_run_nxt = 1'b0;
        skip_nxt   = 8'h00;
        state_nxt  = cl_ret_r;
      end

      // Packed group: code word when repeated or high colour, then colour.
      S_FL0: begin
        if ((grp_n_r > 6'd1) || (grp_c_r > CODE_BASE)) begin
          pk_we    = 1'b1;
          pk_wdata = 8'(grp_n_r) + CODE_BASE;
          pc_nxt   = pc_r + PW'(1);
        end
        state_nxt = S_FL1;
      end

      S_FL1: begin
        pk_we     = 1'b1;
        pk_wdata  = grp_c_r;
        pc_nxt    = pc_r + PW'(1);
        grp_n_nxt = 6'd0;
        state_nxt = fl_ret_r;
      end

      // Record tags, or the empty-column word.
      S_FIN: begin
        raw_we    = 1'b1;
        raw_waddr = '0;
        if (pu_r == PW'(2)) begin
          raw_wdata    = EMPTY_COL;
          sel_nxt      = 1'b0;
          emit_len_nxt = PW'(1);
          emit_ptr_nxt = '0;
          fill_nxt     = '0;
          strobe_nxt   = 1'b1;
          bv_nxt       = 1'b0;
          byte_nxt     = 8'h00;
          last_nxt     = 1'b0;
          ref_nxt      = 1'b0;
          state_nxt    = S_IDLE;
        end else begin
          raw_wdata = RAW_TAG;
          pk_we     = 1'b1;
          pk_waddr  = '0;
          pk_wdata  = PACKED_TAG;
          state_nxt = S_FIN2;
        end
      end

      // Length words and choice of the shorter record.
      S_FIN2: begin
        raw_we       = 1'b1;
        raw_waddr    = PW'(1);
        raw_wdata    = 8'(pu_r - PW'(2));
        pk_we        = 1'b1;
        pk_waddr     = PW'(1);
        pk_wdata     = 8'(pc_r - PW'(2));
        sel_nxt      = pc_r < pu_r;
        emit_len_nxt = (len_full > PW'(RECORD_DEPTH)) ? PW'(RECORD_DEPTH) : len_full;
        emit_ptr_nxt = '0;
        fill_nxt     = '0;
        strobe_nxt   = 1'b1;
        bv_nxt       = 1'b0;
        byte_nxt     = 8'h00;
        last_nxt     = 1'b0;
        ref_nxt      = 1'b0;
        state_nxt    = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Bytes past the record depth are dropped.
  assign raw_we_g = raw_we && (raw_waddr < PW'(RECORD_DEPTH));
  assign pk_we_g  = pk_we && (pk_waddr < PW'(RECORD_DEPTH));

  // State, control registers and the output strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fl_ret_r   <= S_EV;
      cl_ret_r   <= S_EV;
      fb_r       <= FB_NONE;
      fill_r     <= '0;
      emit_ptr_r <= '0;
      emit_len_r <= '0;
      sel_r      <= 1'b0;
      strobe_r   <= 1'b0;
      in_run_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fl_ret_r   <= fl_ret_nxt;
      cl_ret_r   <= cl_ret_nxt;
      fb_r       <= fb_nxt;
      fill_r     <= fill_nxt;
      emit_ptr_r <= emit_ptr_nxt;
      emit_len_r <= emit_len_nxt;
      sel_r      <= sel_nxt;
      strobe_r   <= strobe_nxt;
      in_run_r   <= in_run_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    y_r      <= y_nxt;
    pu_r     <= pu_nxt;
    pc_r     <= pc_nxt;
    run_pu_r <= run_pu_nxt;
    run_pc_r <= run_pc_nxt;
    skip_r   <= skip_nxt;
    grp_n_r  <= grp_n_nxt;
    grp_c_r  <= grp_c_nxt;
    bv_r     <= bv_nxt;
    byte_r   <= byte_nxt;
    last_r   <= last_nxt;
    ref_r    <= ref_nxt;
  end

  // Column store: changed mark and pixel.
  cdre_ram #(.WIDTH(9), .DEPTH(MAX_HEIGHT)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .re    (col_re),
    .raddr (y_r[CAW-1:0]),
    .rdata (col_rdata)
  );

  // Raw record.
  cdre_ram #(.WIDTH(8), .DEPTH(RECORD_DEPTH)) u_raw_ram (
    .clk   (clk),
    .we    (raw_we_g),
    .waddr (raw_waddr[RAW_AW-1:0]),
    .wdata (raw_wdata),
    .re    (1'b1),
    .raddr (emit_ptr_r[RAW_AW-1:0]),
    .rdata (raw_rdata)
  );

  // Packed record.
  cdre_ram #(.WIDTH(8), .DEPTH(RECORD_DEPTH)) u_pk_ram (
    .clk   (clk),
    .we    (pk_we_g),
    .waddr (pk_waddr[RAW_AW-1:0]),
    .wdata (pk_wdata),
    .re    (1'b1),
    .raddr (emit_ptr_r[RAW_AW-1:0]),
    .rdata (pk_rdata)
  );

  assign busy            = state_r != S_IDLE;
  assign out_strobe      = strobe_r;
  assign out_byte_valid  = bv_r;
  assign out_byte        = byte_r;
  assign out_record_last = last_r;
  assign out_refused     = ref_r;

  // A refused word never carries a byte, and the last marker needs a byte.
  `CDR_ASSERT_SAME(a_ref_no_byte, clk, rst_n, strobe_r && ref_r, !bv_r)
  `CDR_ASSERT_SAME(a_last_valid, clk, rst_n, strobe_r && last_r, bv_r)
  // The read pointer stays inside a pending record.
  `CDR_ASSERT_SAME(a_ptr_in_rec, clk, rst_n, emit_len_r != '0,
                   (emit_ptr_r < emit_len_r) && (emit_len_r <= PW'(RECORD_DEPTH)))
  // A record read always answers in the cycle after S_EMIT, with the block back in idle.
  `CDR_ASSERT_NEXT(a_emit_answers, clk, rst_n, state_r == S_EMIT,
                   strobe_r && bv_r && (state_r == S_IDLE))

endmodule
